@@ hdl/lrmu_pkg.sv @@
// ----------------------------------------------------------------------------
// lrmu_pkg
// Shared widths, codes, payload types and control structs of the lidar ray
// map update core.
// ----------------------------------------------------------------------------
package lrmu_pkg;

    localparam int MAP_SIDE_MAX = 512;
    localparam int COORD_W      = $clog2(MAP_SIDE_MAX);
    localparam int SIDE_W       = $clog2(MAP_SIDE_MAX + 1);
    localparam int MAP_DEPTH    = MAP_SIDE_MAX * MAP_SIDE_MAX;
    localparam int ADDR_W       = $clog2(MAP_DEPTH);

    localparam int SIDE_REG_W   = 10;
    localparam int WEIGHT_W     = 9;
    localparam int CFG_W        = 10;
    localparam int CELL_W       = 8;
    localparam int CNT_W        = 11;

    // coordinate, error term, profile, blend sum and divider operand widths
    localparam int CW           = 18;
    localparam int ERR_W        = 20;
    localparam int PIX_W        = 20;
    localparam int SUM_W        = 32;
    localparam int DVD_W        = 34;
    localparam int DVS_W        = CW;

    localparam logic [SIDE_REG_W-1:0] MAP_SIDE_RST = 10'd512;
    localparam logic [WEIGHT_W-1:0]   BLEND_RST    = 9'd50;
    localparam logic [CELL_W-1:0]     CELL_RST     = 8'd128;
    localparam logic [CELL_W-1:0]     CELL_MAX     = 8'd255;

    typedef enum logic {
        CFG_MAP_SIDE     = 1'b0,
        CFG_BLEND_WEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_TRACE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_OUTSIDE    = 2'd1,
        ST_DEGEN      = 2'd2,
        ST_ZERO_WIDTH = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic [7:0]         write_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  cell_value;
        logic [10:0] cells_updated;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RW_ADDR,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_WR_CELL,
        S_CLIPX,
        S_DIVX,
        S_APPLYX,
        S_CLIPY,
        S_DIVY,
        S_APPLYY,
        S_SETUP,
        S_INCST,
        S_DIVINC,
        S_PREP,
        S_WALK_A,
        S_WALK_B,
        S_WALK_C,
        S_WALK_D,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    cell_addr;
        logic    rd_issue;
        logic    rd_take;
        logic    wr_cell;
        logic    div_clipx;
        logic    apply_x;
        logic    div_clipy;
        logic    apply_y;
        logic    setup;
        logic    div_inc;
        logic    prep;
        logic    walk_a;
        logic    walk_b;
        logic    walk_c;
        logic    walk_d;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        t_cmd cmd;
        logic robot_out;
        logic clipx_need;
        logic clipx_degen;
        logic clipy_need;
        logic clipy_degen;
        logic derr_zero;
        logic div_busy;
        logic div_done;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/lidar_ray_map_update_core.sv @@
// ----------------------------------------------------------------------------
// lidar_ray_map_update_core
// Square 8-bit occupancy map with laser ray integration and single cell
// read and write.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole map to 128, one cell per cycle
// (all MAP_SIDE_MAX * MAP_SIDE_MAX cells, 262144 at the default size), and
// accepts no request until the sweep ends; configuration writes are taken
// at any time. One request is worked at a time. A read passes through the
// dispatch, address, read issue and read take states, a write through
// dispatch, address and cell write, and a rejected or unused command goes
// from dispatch straight to the result state, which hands off the result
// once the output register is free. A trace uses the shared divider for
// each edge clip (zero, one or two) and once more for the profile slope,
// then walks the ray cell by cell (read, blend multiply, saturate, write
// back through the map memory write port). The next request is accepted
// while a result still waits in the output register.
module lidar_ray_map_update_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lrmu_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lrmu_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [lrmu_pkg::CFG_W-1:0]    i_cfg_data
);

    lrmu_pkg::t_dp_cmd  dp_cmd;
    lrmu_pkg::t_dp_stat dp_stat;

    lrmu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    lrmu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // never overwrite a result that has not been taken
    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    // a result shows up only after the controller loads one
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.res_load))
        else $error("output valid without a result load");

    // divider is started only when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.div_clipx || dp_cmd.div_clipy || dp_cmd.div_inc) |-> !dp_stat.div_busy)
        else $error("divider restarted while busy");

endmodule

@@ hdl/lrmu_ram.sv @@
// ----------------------------------------------------------------------------
// lrmu_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lrmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lrmu_div.sv @@
// ----------------------------------------------------------------------------
// lrmu_div
// Signed radix-2 restoring divider, quotient truncated toward zero.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrmu_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [lrmu_pkg::DVD_W-1:0] i_dividend,
    input  logic signed [lrmu_pkg::DVS_W-1:0] i_divisor,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [lrmu_pkg::DVD_W-1:0] o_quotient
);

    localparam int DVD_W = lrmu_pkg::DVD_W;
    localparam int DVS_W = lrmu_pkg::DVS_W;
    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W:0]    r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic              r_neg;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              take;
    logic [DVD_W-1:0]  dvd_mag;
    logic [DVS_W-1:0]  dvs_mag;

    assign dvd_mag = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    assign dvs_mag = i_divisor[DVS_W-1] ? DVS_W'(-i_divisor) : DVS_W'(i_divisor);

    assign rem_sh  = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
    assign take    = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= dvd_mag;
            r_dvs <= dvs_mag;
            r_neg <= i_dividend[DVD_W-1] ^ i_divisor[DVS_W-1];
        end else if (r_busy) begin
            r_rem <= take ? rem_sub : rem_sh;
            r_quo <= {r_quo[DVD_W-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

@@ hdl/lrmu_dp.sv @@
// ----------------------------------------------------------------------------
// lrmu_dp
// Datapath: configuration, command registers, ray clipping, Bresenham walk,
// cell blend, map memory and the result register.
// ----------------------------------------------------------------------------
module lrmu_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [lrmu_pkg::CFG_W-1:0]       i_cfg_data,
    input  lrmu_pkg::t_in_item               i_in_item,
    output lrmu_pkg::t_out_item              o_out_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  lrmu_pkg::t_dp_cmd                i_cmd,
    output lrmu_pkg::t_dp_stat               o_stat
);

    localparam int CW      = lrmu_pkg::CW;
    localparam int ERR_W   = lrmu_pkg::ERR_W;
    localparam int PIX_W   = lrmu_pkg::PIX_W;
    localparam int SUM_W   = lrmu_pkg::SUM_W;
    localparam int SIDE_W  = lrmu_pkg::SIDE_W;
    localparam int COORD_W = lrmu_pkg::COORD_W;
    localparam int ADDR_W  = lrmu_pkg::ADDR_W;
    localparam int WT_W    = lrmu_pkg::WEIGHT_W;
    localparam int AMUL_W  = COORD_W + SIDE_W;

    function automatic logic signed [CW-1:0] abs_cw(input logic signed [CW-1:0] v);
        abs_cw = (v < 0) ? -v : v;
    endfunction

    // configuration
    logic [lrmu_pkg::SIDE_REG_W-1:0] r_map_side;
    logic [WT_W-1:0]                 r_blend_weight;
    logic [SIDE_W-1:0]               side;
    logic [WT_W-1:0]                 weight;
    logic [WT_W+1:0]                 w_comp;
    logic signed [CW-1:0]            n_s;
    logic signed [CW-1:0]            n_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_side     <= lrmu_pkg::MAP_SIDE_RST;
            r_blend_weight <= lrmu_pkg::BLEND_RST;
        end else if (i_cfg_we) begin
            case (lrmu_pkg::t_cfg_idx'(i_cfg_idx))
                lrmu_pkg::CFG_MAP_SIDE:     r_map_side <= i_cfg_data;
                lrmu_pkg::CFG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data[WT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_map_side) > lrmu_pkg::MAP_SIDE_MAX) begin
            side = SIDE_W'(lrmu_pkg::MAP_SIDE_MAX);
        end else if (r_map_side < 10'd2) begin
            side = SIDE_W'(2);
        end else begin
            side = SIDE_W'(r_map_side);
        end
        weight = (r_blend_weight > 9'd256) ? 9'd256 : r_blend_weight;
    end

    assign w_comp = 11'd1024 - {2'b00, weight};
    assign n_s    = $signed(CW'(side));
    assign n_m1   = n_s - CW'(1);

    // item and walk registers
    logic [1:0]            r_cmd;
    logic signed [CW-1:0]  r_x1, r_y1, r_x2, r_y2, r_xp, r_yp;
    logic [7:0]            r_wval;
    logic signed [CW-1:0]  r_xc, r_yc;
    logic signed [CW-1:0]  r_cx, r_cy;
    logic signed [CW-1:0]  r_dxc, r_dyc, r_dx, r_derr;
    logic                  r_xmaj, r_sx, r_sy;
    logic signed [ERR_W-1:0] r_err, r_horiz, r_diago, r_hi, r_lo;
    logic [7:0]            r_inc;
    logic signed [PIX_W-1:0] r_pix;
    logic [CW-1:0]         r_k;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_inmap;
    logic signed [SUM_W-1:0] r_prod, r_sum;
    logic [lrmu_pkg::CNT_W-1:0] r_cnt;
    logic [7:0]            r_value;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic                  r_out_valid;
    lrmu_pkg::t_out_item   r_out;

    // divider operands: one shared multiplier builds the dividend
    logic signed [CW-1:0]      mul_a, mul_b, dvs_sel;
    logic signed [2*CW-1:0]    mul_p;
    logic                      div_start, div_busy, div_done;
    logic signed [lrmu_pkg::DVD_W-1:0] quo;

    always_comb begin
        if (i_cmd.div_clipy) begin
            if (r_yc < 0) begin
                mul_a = r_yc;
                mul_b = r_xc - r_x1;
            end else begin
                mul_a = r_x1 - r_xc;
                mul_b = n_m1 - r_yc;
            end
            dvs_sel = r_y1 - r_yc;
        end else if (i_cmd.div_inc) begin
            mul_a   = CW'(255);
            mul_b   = CW'(1);
            dvs_sel = r_derr;
        end else begin
            if (r_xc < 0) begin
                mul_a = r_xc;
                mul_b = r_y1 - r_yc;
            end else begin
                mul_a = r_yc - r_y1;
                mul_b = n_m1 - r_xc;
            end
            dvs_sel = r_xc - r_x1;
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign div_start = i_cmd.div_clipx | i_cmd.div_clipy | i_cmd.div_inc;

    lrmu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_p[lrmu_pkg::DVD_W-1:0]),
        .i_divisor  (dvs_sel),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // setup terms
    logic signed [CW-1:0] dx_u, dy_u, dxc_u, dyc_u;
    logic                 xmaj;

    assign dx_u  = abs_cw(r_x2 - r_x1);
    assign dy_u  = abs_cw(r_y2 - r_y1);
    assign dxc_u = abs_cw(r_xc - r_x1);
    assign dyc_u = abs_cw(r_yc - r_y1);
    assign xmaj  = dx_u > dy_u;

    // prep terms
    logic signed [ERR_W-1:0] dxc_e, dyc_e, dx_e, derr_e, horiz_v, err_v, hi_v;

    assign dxc_e   = ERR_W'(r_dxc);
    assign dyc_e   = ERR_W'(r_dyc);
    assign dx_e    = ERR_W'(r_dx);
    assign derr_e  = ERR_W'(r_derr);
    assign horiz_v = dyc_e + dyc_e;
    assign err_v   = horiz_v - dxc_e;
    assign hi_v    = dx_e - derr_e;

    // walk terms
    logic signed [ERR_W-1:0] k_e;
    logic signed [PIX_W-1:0] inc_e, pix_n;
    logic                    inmap_v;
    logic [AMUL_W-1:0]       addr_full;
    logic signed [CW-1:0]    sx_step, sy_step, cx_n, cy_n;
    logic signed [ERR_W-1:0] err_n;
    logic [7:0]              sat_v;
    logic [7:0]              ram_rdata;
    logic signed [2*WT_W+3:0] old_term;

    assign k_e   = $signed(ERR_W'(r_k));
    assign inc_e = $signed(PIX_W'(r_inc));

    always_comb begin
        pix_n = r_pix;
        if (k_e > r_lo) begin
            if (k_e <= r_hi) begin
                pix_n = r_pix - inc_e;
            end else begin
                pix_n = r_pix + inc_e;
            end
        end
    end

    assign inmap_v   = (r_cx >= 0) && (r_cx < n_s) && (r_cy >= 0) && (r_cy < n_s);
    assign addr_full = AMUL_W'(r_cy[COORD_W-1:0]) * AMUL_W'(side)
                     + AMUL_W'(r_cx[COORD_W-1:0]);

    assign sx_step = {{(CW-1){~r_sx}}, 1'b1};
    assign sy_step = {{(CW-1){~r_sy}}, 1'b1};

    always_comb begin
        cx_n = r_cx;
        cy_n = r_cy;
        if (r_err > 0) begin
            if (r_xmaj) begin
                cy_n = r_cy + sy_step;
            end else begin
                cx_n = r_cx + sx_step;
            end
            err_n = r_err + r_diago;
        end else begin
            err_n = r_err + r_horiz;
        end
        if (r_xmaj) begin
            cx_n = cx_n + sx_step;
        end else begin
            cy_n = cy_n + sy_step;
        end
    end

    assign old_term = $signed({1'b0, ram_rdata}) * $signed({1'b0, w_comp});

    always_comb begin
        if (r_sum < 0) begin
            sat_v = '0;
        end else if (|r_sum[SUM_W-1:18]) begin
            sat_v = lrmu_pkg::CELL_MAX;
        end else begin
            sat_v = r_sum[17:10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_item.command;
            r_x1    <= CW'(i_in_item.start_x);
            r_y1    <= CW'(i_in_item.start_y);
            r_x2    <= CW'(i_in_item.end_x);
            r_y2    <= CW'(i_in_item.end_y);
            r_xp    <= CW'(i_in_item.hit_x);
            r_yp    <= CW'(i_in_item.hit_y);
            r_xc    <= CW'(i_in_item.end_x);
            r_yc    <= CW'(i_in_item.end_y);
            r_cx    <= CW'(i_in_item.start_x);
            r_cy    <= CW'(i_in_item.start_y);
            r_wval  <= i_in_item.write_value;
            r_value <= '0;
            r_cnt   <= '0;
        end
        if (i_cmd.apply_x) begin
            r_yc <= r_yc + quo[CW-1:0];
            r_xc <= (r_xc < 0) ? '0 : n_m1;
        end
        if (i_cmd.apply_y) begin
            r_xc <= r_xc + quo[CW-1:0];
            r_yc <= (r_yc < 0) ? '0 : n_m1;
        end
        if (i_cmd.setup) begin
            r_xmaj <= xmaj;
            r_sx   <= r_x2 > r_x1;
            r_sy   <= r_y2 > r_y1;
            r_dxc  <= xmaj ? dxc_u : dyc_u;
            r_dyc  <= xmaj ? dyc_u : dxc_u;
            r_dx   <= xmaj ? dx_u : dy_u;
            r_derr <= xmaj ? abs_cw(r_xp - r_x2) : abs_cw(r_yp - r_y2);
        end
        if (i_cmd.prep) begin
            r_horiz <= horiz_v;
            r_err   <= err_v;
            r_diago <= err_v - dxc_e;
            r_hi    <= hi_v;
            r_lo    <= hi_v - derr_e;
            r_inc   <= quo[7:0];
            r_pix   <= PIX_W'(255);
            r_cx    <= r_x1;
            r_cy    <= r_y1;
            r_k     <= '0;
        end
        if (i_cmd.cell_addr || i_cmd.walk_a) begin
            r_addr  <= addr_full[ADDR_W-1:0];
            r_inmap <= inmap_v;
        end
        if (i_cmd.walk_a) begin
            r_pix <= pix_n;
        end
        if (i_cmd.walk_b) begin
            r_prod <= $signed(SUM_W'($signed({1'b0, weight}))) * SUM_W'(r_pix);
        end
        if (i_cmd.walk_c) begin
            r_sum <= SUM_W'(old_term) + r_prod;
        end
        if (i_cmd.walk_d) begin
            r_cx  <= cx_n;
            r_cy  <= cy_n;
            r_err <= err_n;
            r_k   <= r_k + 1'b1;
            r_cnt <= r_cnt + lrmu_pkg::CNT_W'(r_inmap);
        end
        if (i_cmd.rd_take) begin
            r_value <= ram_rdata;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // map memory
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = sat_v;
        if (i_cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = lrmu_pkg::CELL_RST;
        end else if (i_cmd.wr_cell) begin
            ram_we    = 1'b1;
            ram_wdata = r_wval;
        end else if (i_cmd.walk_d) begin
            ram_we    = r_inmap;
        end
    end

    assign ram_re = i_cmd.rd_issue | (i_cmd.walk_b & r_inmap);

    lrmu_ram #(
        .WIDTH (lrmu_pkg::CELL_W),
        .DEPTH (lrmu_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status        <= i_cmd.res_status;
            r_out.cell_value    <= r_value;
            r_out.cells_updated <= r_cnt;
        end
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.clear_last  = r_clr_addr == ADDR_W'(lrmu_pkg::MAP_DEPTH - 1);
        o_stat.cmd         = lrmu_pkg::t_cmd'(r_cmd);
        o_stat.robot_out   = (r_x1 < 0) || (r_x1 >= n_s) || (r_y1 < 0) || (r_y1 >= n_s);
        o_stat.clipx_need  = (r_xc < 0) || (r_xc >= n_s);
        o_stat.clipx_degen = r_xc == r_x1;
        o_stat.clipy_need  = (r_yc < 0) || (r_yc >= n_s);
        o_stat.clipy_degen = r_yc == r_y1;
        o_stat.derr_zero   = r_derr == '0;
        o_stat.div_busy    = div_busy;
        o_stat.div_done    = div_done;
        o_stat.walk_last   = r_k == CW'(r_dxc);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

@@ hdl/lrmu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrmu_ctrl
// Controller: sequences the clearing pass, cell access, ray clipping,
// profile setup and the per-cell read-modify-write walk.
// ----------------------------------------------------------------------------
module lrmu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrmu_pkg::t_dp_stat i_stat,
    output lrmu_pkg::t_dp_cmd  o_cmd
);

    lrmu_pkg::t_state  r_state, n_state;
    lrmu_pkg::t_status r_res_status, n_res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lrmu_pkg::S_CLEAR;
            r_res_status <= lrmu_pkg::ST_DONE;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
        end
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        case (r_state)
            lrmu_pkg::S_CLEAR: begin
                if (i_stat.clear_last) n_state = lrmu_pkg::S_IDLE;
            end
            lrmu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state      = lrmu_pkg::S_DISPATCH;
                    n_res_status = lrmu_pkg::ST_DONE;
                end
            end
            lrmu_pkg::S_DISPATCH: begin
                case (i_stat.cmd)
                    lrmu_pkg::CMD_TRACE,
                    lrmu_pkg::CMD_READ,
                    lrmu_pkg::CMD_WRITE: begin
                        if (i_stat.robot_out) begin
                            n_state      = lrmu_pkg::S_RESULT;
                            n_res_status = lrmu_pkg::ST_OUTSIDE;
                        end else if (i_stat.cmd == lrmu_pkg::CMD_TRACE) begin
                            n_state = lrmu_pkg::S_CLIPX;
                        end else begin
                            n_state = lrmu_pkg::S_RW_ADDR;
                        end
                    end
                    default: n_state = lrmu_pkg::S_RESULT;
                endcase
            end
            lrmu_pkg::S_RW_ADDR: begin
                n_state = (i_stat.cmd == lrmu_pkg::CMD_READ) ? lrmu_pkg::S_RD_ISSUE
                                                             : lrmu_pkg::S_WR_CELL;
            end
            lrmu_pkg::S_RD_ISSUE: n_state = lrmu_pkg::S_RD_TAKE;
            lrmu_pkg::S_RD_TAKE:  n_state = lrmu_pkg::S_RESULT;
            lrmu_pkg::S_WR_CELL:  n_state = lrmu_pkg::S_RESULT;
            lrmu_pkg::S_CLIPX: begin
                if (!i_stat.clipx_need) begin
                    n_state = lrmu_pkg::S_CLIPY;
                end else if (i_stat.clipx_degen) begin
                    n_state      = lrmu_pkg::S_RESULT;
                    n_res_status = lrmu_pkg::ST_DEGEN;
                end else begin
                    n_state = lrmu_pkg::S_DIVX;
                end
            end
            lrmu_pkg::S_DIVX: begin
                if (i_stat.div_done) n_state = lrmu_pkg::S_APPLYX;
            end
            lrmu_pkg::S_APPLYX: n_state = lrmu_pkg::S_CLIPY;
            lrmu_pkg::S_CLIPY: begin
                if (!i_stat.clipy_need) begin
                    n_state = lrmu_pkg::S_SETUP;
                end else if (i_stat.clipy_degen) begin
                    n_state      = lrmu_pkg::S_RESULT;
                    n_res_status = lrmu_pkg::ST_DEGEN;
                end else begin
                    n_state = lrmu_pkg::S_DIVY;
                end
            end
            lrmu_pkg::S_DIVY: begin
                if (i_stat.div_done) n_state = lrmu_pkg::S_APPLYY;
            end
            lrmu_pkg::S_APPLYY: n_state = lrmu_pkg::S_SETUP;
            lrmu_pkg::S_SETUP:  n_state = lrmu_pkg::S_INCST;
            lrmu_pkg::S_INCST: begin
                if (i_stat.derr_zero) begin
                    n_state      = lrmu_pkg::S_RESULT;
                    n_res_status = lrmu_pkg::ST_ZERO_WIDTH;
                end else begin
                    n_state = lrmu_pkg::S_DIVINC;
                end
            end
            lrmu_pkg::S_DIVINC: begin
                if (i_stat.div_done) n_state = lrmu_pkg::S_PREP;
            end
            lrmu_pkg::S_PREP:   n_state = lrmu_pkg::S_WALK_A;
            lrmu_pkg::S_WALK_A: n_state = lrmu_pkg::S_WALK_B;
            lrmu_pkg::S_WALK_B: n_state = lrmu_pkg::S_WALK_C;
            lrmu_pkg::S_WALK_C: n_state = lrmu_pkg::S_WALK_D;
            lrmu_pkg::S_WALK_D: begin
                n_state = i_stat.walk_last ? lrmu_pkg::S_RESULT : lrmu_pkg::S_WALK_A;
            end
            lrmu_pkg::S_RESULT: begin
                if (i_stat.out_free) n_state = lrmu_pkg::S_IDLE;
            end
            default: n_state = lrmu_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = r_res_status;
        o_in_ready       = 1'b0;
        case (r_state)
            lrmu_pkg::S_CLEAR:    o_cmd.clear_wr = 1'b1;
            lrmu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lrmu_pkg::S_RW_ADDR:  o_cmd.cell_addr = 1'b1;
            lrmu_pkg::S_RD_ISSUE: o_cmd.rd_issue = 1'b1;
            lrmu_pkg::S_RD_TAKE:  o_cmd.rd_take = 1'b1;
            lrmu_pkg::S_WR_CELL:  o_cmd.wr_cell = 1'b1;
            lrmu_pkg::S_CLIPX: begin
                o_cmd.div_clipx = i_stat.clipx_need & ~i_stat.clipx_degen;
            end
            lrmu_pkg::S_APPLYX:   o_cmd.apply_x = 1'b1;
            lrmu_pkg::S_CLIPY: begin
                o_cmd.div_clipy = i_stat.clipy_need & ~i_stat.clipy_degen;
            end
            lrmu_pkg::S_APPLYY:   o_cmd.apply_y = 1'b1;
            lrmu_pkg::S_SETUP:    o_cmd.setup = 1'b1;
            lrmu_pkg::S_INCST:    o_cmd.div_inc = ~i_stat.derr_zero;
            lrmu_pkg::S_PREP:     o_cmd.prep = 1'b1;
            lrmu_pkg::S_WALK_A:   o_cmd.walk_a = 1'b1;
            lrmu_pkg::S_WALK_B:   o_cmd.walk_b = 1'b1;
            lrmu_pkg::S_WALK_C:   o_cmd.walk_c = 1'b1;
            lrmu_pkg::S_WALK_D:   o_cmd.walk_d = 1'b1;
            lrmu_pkg::S_RESULT:   o_cmd.res_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
